[rtl/nst_pkg.sv]
// shared types and constants of the address and port translator
// used by every module of the block; no dependencies
`default_nettype none

package nst_pkg;

    // request classes decided by the front end
    typedef enum logic [1:0] {
        KIND_DROP    = 2'd0,
        KIND_PASS    = 2'd1,
        KIND_INSIDE  = 2'd2,
        KIND_OUTSIDE = 2'd3
    } kind_t;

    // forwarding decision codes
    localparam logic [1:0] ACT_DROP    = 2'd0;
    localparam logic [1:0] ACT_INSIDE  = 2'd1;
    localparam logic [1:0] ACT_OUTSIDE = 2'd2;

    // arrival sides
    localparam logic [1:0] SIDE_INSIDE  = 2'd1;
    localparam logic [1:0] SIDE_OUTSIDE = 2'd2;

    // header codes
    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [15:0] ETH_ARP      = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  ICMP_REQUEST = 8'd8;
    localparam logic [7:0]  ICMP_REPLY   = 8'd0;

    // minimum frame lengths
    localparam logic [15:0] LEN_ETH = 16'd14;
    localparam logic [15:0] LEN_IP  = 16'd34;
    localparam logic [15:0] LEN_UDP = 16'd42;
    localparam logic [15:0] LEN_TCP = 16'd54;

    // port allocation
    localparam logic [15:0] PORT_FLOOR = 16'd1024;
    localparam logic [16:0] PORT_WRAP  = 17'd65535;

    // classified request between front and back
    typedef struct packed {
        kind_t       kind;
        logic        icmp;
        logic [1:0]  act;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] ipck;
        logic [15:0] l4ck;
    } nst_req_t;

    // translated result
    typedef struct packed {
        logic [1:0]  act;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] ipck;
        logic [15:0] l4ck;
        logic        created;
    } nst_res_t;

endpackage

`default_nettype wire

[rtl/nst_front.sv]
// front end: accepts header requests and classifies them
// depends on nst_pkg
`default_nettype none

module nst_front
(
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [175:0]         s_tdata,
    input  wire logic [1:0]           s_tuser,
    output logic                      push,
    output nst_pkg::nst_req_t         push_req,
    input  wire logic                 q_full
);
    import nst_pkg::*;

    logic [15:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [7:0]  icmp_type;
    logic        is_icmp;
    logic        l4_ok;

    // unpack header fields
    assign frame_len   = s_tdata[15:0];
    assign ether_type  = s_tdata[31:16];
    assign ip_protocol = s_tdata[39:32];
    assign icmp_type   = s_tdata[143:136];

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // protocol and length checks
    always_comb
    begin
        is_icmp = 1'b0;
        l4_ok   = 1'b0;
        case (ip_protocol)
            PROTO_ICMP:
            begin
                is_icmp = 1'b1;
                l4_ok   = (frame_len >= LEN_UDP) &&
                          ((icmp_type == ICMP_REQUEST) || (icmp_type == ICMP_REPLY));
            end
            PROTO_UDP: l4_ok = (frame_len >= LEN_UDP);
            PROTO_TCP: l4_ok = (frame_len >= LEN_TCP);
            default:   l4_ok = 1'b0;
        endcase
    end

    // classification
    always_comb
    begin
        push_req.kind  = KIND_DROP;
        push_req.icmp  = is_icmp;
        push_req.act   = ACT_DROP;
        push_req.saddr = s_tdata[71:40];
        push_req.daddr = s_tdata[103:72];
        push_req.sport = s_tdata[119:104];
        push_req.dport = s_tdata[135:120];
        push_req.ipck  = s_tdata[159:144];
        push_req.l4ck  = s_tdata[175:160];
        if (frame_len < LEN_ETH)
        begin
            push_req.kind = KIND_DROP;
        end
        else if (ether_type == ETH_ARP)
        begin
            if (s_tuser == SIDE_INSIDE)
            begin
                push_req.kind = KIND_PASS;
                push_req.act  = ACT_OUTSIDE;
            end
            else if (s_tuser == SIDE_OUTSIDE)
            begin
                push_req.kind = KIND_PASS;
                push_req.act  = ACT_INSIDE;
            end
        end
        else if ((ether_type == ETH_IPV4) && (frame_len >= LEN_IP) && l4_ok)
        begin
            if (s_tuser == SIDE_INSIDE)
                push_req.kind = KIND_INSIDE;
            else if (s_tuser == SIDE_OUTSIDE)
                push_req.kind = KIND_OUTSIDE;
        end
    end

endmodule

`default_nettype wire

[rtl/nst_queue.sv]
// two-entry request queue between front and back end
// depends on nst_pkg
`default_nettype none

module nst_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire nst_pkg::nst_req_t push_req,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output nst_pkg::nst_req_t      head
);
    import nst_pkg::*;

    nst_req_t    slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_req;
    end

endmodule

`default_nettype wire

[rtl/nst_back.sv]
// back end: session map scan, inserts, port allocation, checksum update
// depends on nst_pkg
`default_nettype none

module nst_back
#(
    parameter int OUTBOUND_DEPTH = 1024,
    parameter int INBOUND_DEPTH  = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [31:0]       outside_address,
    input  wire logic              q_not_empty,
    input  wire nst_pkg::nst_req_t q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output nst_pkg::nst_res_t      out_res
);
    import nst_pkg::*;

    localparam int OAW = (OUTBOUND_DEPTH > 1) ? $clog2(OUTBOUND_DEPTH) : 1;
    localparam int IAW = (INBOUND_DEPTH > 1) ? $clog2(INBOUND_DEPTH) : 1;
    localparam int IW  = ((OAW > IAW) ? OAW : IAW) + 1;
    localparam int EW  = 144;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_OB_WR = 5'b00100,
        ST_IB_WR = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t         state_reg;
    nst_req_t       req_reg;
    logic           sel_ib_reg;
    logic [IW-1:0]  idx_reg;
    logic           pend_reg;
    logic [95:0]    key_reg;
    logic [31:0]    maddr_reg;
    logic [15:0]    mport_reg;
    logic           created_reg;
    logic           hit_reg;
    logic [OAW:0]   ob_cnt_reg;
    logic [IAW:0]   ib_cnt_reg;
    logic [15:0]    port_cnt_reg;
    logic           out_valid_reg;
    nst_res_t       out_reg;

    logic [EW-1:0]  ob_mem [OUTBOUND_DEPTH];
    logic [EW-1:0]  ib_mem [INBOUND_DEPTH];
    logic [EW-1:0]  ob_rdata_reg;
    logic [EW-1:0]  ib_rdata_reg;

    logic [EW-1:0]  rdata;
    logic [IW-1:0]  cur_cnt;
    logic           issue;
    logic           match;
    logic           miss;
    logic [15:0]    kdport;
    logic [15:0]    port_base;
    logic [16:0]    port_inc;
    logic [15:0]    new_port;
    logic           out_free;
    nst_res_t       res;

    // scan helpers
    assign rdata   = sel_ib_reg ? ib_rdata_reg : ob_rdata_reg;
    assign cur_cnt = sel_ib_reg ? IW'(ib_cnt_reg) : IW'(ob_cnt_reg);
    assign issue   = (idx_reg < cur_cnt);
    assign match   = pend_reg && (rdata[EW-1:48] == key_reg);
    assign miss    = !issue && !pend_reg;
    assign kdport  = req_reg.icmp ? 16'h0000 : req_reg.dport;

    // next translated port: floor at 1024, then increment modulo 65535
    assign port_base = (port_cnt_reg < PORT_FLOOR) ? PORT_FLOOR : port_cnt_reg;
    assign port_inc  = {1'b0, port_base} + 17'd1;
    assign new_port  = (port_inc >= PORT_WRAP) ? 16'(port_inc - PORT_WRAP)
                                               : port_inc[15:0];

    assign out_free  = !out_valid_reg || out_ready;
    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    function automatic logic [19:0] w20(input logic [15:0] v);
        w20 = {4'h0, v};
    endfunction

    function automatic logic [15:0] fold(input logic [19:0] acc);
        logic [19:0] a;
        a = {4'h0, acc[15:0]} + {16'h0, acc[19:16]};
        a = {4'h0, a[15:0]} + {16'h0, a[19:16]};
        a = {4'h0, a[15:0]} + {16'h0, a[19:16]};
        fold = ~a[15:0];
    endfunction

    // result assembly with incremental checksum update
    always_comb
    begin
        logic [31:0] old_a;
        logic [15:0] old_p;
        logic [19:0] addr_terms;
        logic [19:0] acc3;
        logic [19:0] acc4;
        logic        from_inside;
        from_inside = (req_reg.kind == KIND_INSIDE);
        old_a      = from_inside ? req_reg.saddr : req_reg.daddr;
        old_p      = (from_inside || req_reg.icmp) ? req_reg.sport : req_reg.dport;
        addr_terms = w20(~old_a[31:16]) + w20(maddr_reg[31:16]) +
                     w20(~old_a[15:0]) + w20(maddr_reg[15:0]);
        acc3       = w20(16'hFFFF) + w20(~req_reg.ipck) + addr_terms;
        acc4       = w20(16'hFFFF) + w20(~req_reg.l4ck) +
                     (req_reg.icmp ? 20'h0 : addr_terms) +
                     w20(~old_p) + w20(mport_reg) + w20(16'hFFFF);
        res = '0;
        case (req_reg.kind)
            KIND_PASS:
            begin
                res.act   = req_reg.act;
                res.saddr = req_reg.saddr;
                res.daddr = req_reg.daddr;
                res.sport = req_reg.sport;
                res.dport = req_reg.dport;
                res.ipck  = req_reg.ipck;
                res.l4ck  = req_reg.l4ck;
            end
            KIND_INSIDE:
            begin
                res.act     = ACT_OUTSIDE;
                res.saddr   = maddr_reg;
                res.daddr   = req_reg.daddr;
                res.sport   = mport_reg;
                res.dport   = req_reg.dport;
                res.ipck    = fold(acc3);
                res.l4ck    = fold(acc4);
                res.created = created_reg;
            end
            KIND_OUTSIDE:
            begin
                if (hit_reg)
                begin
                    res.act   = ACT_INSIDE;
                    res.saddr = req_reg.saddr;
                    res.daddr = maddr_reg;
                    res.sport = req_reg.icmp ? mport_reg : req_reg.sport;
                    res.dport = req_reg.icmp ? req_reg.dport : mport_reg;
                    res.ipck  = fold(acc3);
                    res.l4ck  = fold(acc4);
                end
            end
            default: res = '0;
        endcase
    end

    // memory read ports, one entry per cycle
    always_ff @(posedge clk)
    begin
        ob_rdata_reg <= ob_mem[idx_reg[OAW-1:0]];
        ib_rdata_reg <= ib_mem[idx_reg[IAW-1:0]];
    end

    // memory write ports, new entries go to the fill count
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OB_WR) && (ob_cnt_reg < (OAW+1)'(OUTBOUND_DEPTH)))
            ob_mem[ob_cnt_reg[OAW-1:0]] <=
                {req_reg.saddr, req_reg.daddr, req_reg.sport, kdport,
                 maddr_reg, mport_reg};
        if ((state_reg == ST_IB_WR) && (ib_cnt_reg < (IAW+1)'(INBOUND_DEPTH)))
            ib_mem[ib_cnt_reg[IAW-1:0]] <=
                {key_reg, req_reg.saddr, req_reg.sport};
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ob_cnt_reg    <= '0;
            ib_cnt_reg    <= '0;
            port_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            sel_ib_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_not_empty)
                    begin
                        req_reg     <= q_head;
                        created_reg <= 1'b0;
                        hit_reg     <= 1'b0;
                        maddr_reg   <= '0;
                        mport_reg   <= '0;
                        idx_reg     <= '0;
                        pend_reg    <= 1'b0;
                        if (q_head.kind == KIND_INSIDE)
                        begin
                            sel_ib_reg <= 1'b0;
                            key_reg    <= {q_head.saddr, q_head.daddr, q_head.sport,
                                           q_head.icmp ? 16'h0000 : q_head.dport};
                            state_reg  <= ST_SCAN;
                        end
                        else if (q_head.kind == KIND_OUTSIDE)
                        begin
                            sel_ib_reg <= 1'b1;
                            key_reg    <= {q_head.saddr, q_head.daddr,
                                           q_head.icmp ? 16'h0000 : q_head.sport,
                                           q_head.icmp ? q_head.sport : q_head.dport};
                            state_reg  <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                        idx_reg <= idx_reg + IW'(1);
                    pend_reg <= issue;
                    if (match)
                    begin
                        pend_reg <= 1'b0;
                        if (!sel_ib_reg || (req_reg.kind == KIND_OUTSIDE))
                        begin
                            maddr_reg <= rdata[47:16];
                            mport_reg <= rdata[15:0];
                            hit_reg   <= 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                    else if (miss)
                    begin
                        if (!sel_ib_reg)
                        begin
                            maddr_reg    <= outside_address;
                            mport_reg    <= new_port;
                            port_cnt_reg <= new_port;
                            created_reg  <= 1'b1;
                            state_reg    <= ST_OB_WR;
                        end
                        else if (req_reg.kind == KIND_INSIDE)
                        begin
                            state_reg <= ST_IB_WR;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_OB_WR:
                begin
                    if (ob_cnt_reg < (OAW+1)'(OUTBOUND_DEPTH))
                        ob_cnt_reg <= ob_cnt_reg + (OAW+1)'(1);
                    // reverse key for the inbound map
                    key_reg    <= {req_reg.daddr, maddr_reg, kdport, mport_reg};
                    sel_ib_reg <= 1'b1;
                    idx_reg    <= '0;
                    pend_reg   <= 1'b0;
                    state_reg  <= ST_SCAN;
                end
                ST_IB_WR:
                begin
                    if (ib_cnt_reg < (IAW+1)'(INBOUND_DEPTH))
                        ib_cnt_reg <= ib_cnt_reg + (IAW+1)'(1);
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_reg       <= res;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/napt_session_translator_unit.sv]
// Address and port translator for IPv4 UDP, TCP and ICMP echo headers.
// Requests arrive on the s_ stream (tuser = arrival side, tdata = header
// fields), one result per request leaves on the m_ stream (tuser = action,
// tdata = translated header and session flag). A drop gives all zeros.
// The outside address is written through cfg_wr_en / cfg_wr_data; the user
// must do so only while idle, as the block itself does not enforce it.
// A classifying front end feeds a two-entry request queue; the back end
// scans the session maps one stored entry per cycle from a registered
// memory read port and inserts new sessions at the map's fill count.
// The back end takes a drop or ARP request from its pop straight to the
// result state; a lookup reads map entries in turn up to a hit or the fill
// count. A new session writes the outbound entry, scans the inbound map and
// writes the reverse entry unless found; a full map takes no write. The scan
// length is what sets the rate. The result sits in an output register; while
// the receiver stalls, the back end can hold one more request, the queue up to
// two, then s_tready falls. Reset empties both maps (fill counts to zero),
// clears the port counter and the outside address; no clearing pass is needed.
`default_nettype none

module napt_session_translator_unit
#(
    parameter int OUTBOUND_DEPTH = 1024,
    parameter int INBOUND_DEPTH  = 1024
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [31:0]  cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // frame_len, ether_type, ip_protocol, src_addr, dst_addr, src_port,
    // dst_port, icmp_type, ip_checksum, l4_checksum
    input  wire logic [175:0] s_tdata,
    // in_port
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // src_addr_out, dst_addr_out, src_port_out, dst_port_out,
    // ip_checksum_out, l4_checksum_out, session_created, zero pad
    output logic [135:0]      m_tdata,
    // action
    output logic [1:0]        m_tuser
);
    import nst_pkg::*;

    logic [31:0] outside_address_reg;
    logic        push;
    nst_req_t    push_req;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    nst_req_t    q_head;
    nst_res_t    res;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outside_address_reg <= '0;
        else if (cfg_wr_en)
            outside_address_reg <= cfg_wr_data;
    end

    nst_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_req (push_req),
        .q_full   (q_full)
    );

    nst_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    nst_back
    #(
        .OUTBOUND_DEPTH (OUTBOUND_DEPTH),
        .INBOUND_DEPTH  (INBOUND_DEPTH)
    )
    u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .outside_address (outside_address_reg),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_res         (res)
    );

    // output packing
    assign m_tuser = res.act;
    assign m_tdata = {7'h00, res.created, res.l4ck, res.ipck, res.dport, res.sport,
                      res.daddr, res.saddr};

`ifndef SYNTH
    // a dropped request carries an all-zero header
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ACT_DROP)) |-> (m_tdata == '0))
        else $error("drop result with nonzero header");

    // only outbound translations create sessions
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[128]) |-> (m_tuser == ACT_OUTSIDE))
        else $error("session created on non-outbound result");

    // an updated ip checksum of a created session never folds to negative zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[128]) |-> (m_tdata[111:96] != 16'hFFFF))
        else $error("updated ip checksum is 0xffff");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// testbench for napt_session_translator_unit: predicts each translated header
// in a scoreboard class, drives requests from tasks and randomises m_tready
// depends on rtl/nst_pkg.sv and rtl/napt_session_translator_unit.sv
`timescale 1ns / 100ps

module tb_top;
    import nst_pkg::*;

    localparam int MAP_DEPTH = 1024;

    // one parsed header as it enters the block
    typedef struct {
        logic [1:0]  in_port;
        logic [15:0] frame_len;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  icmp_type;
        logic [15:0] ip_checksum;
        logic [15:0] l4_checksum;
    } header_t;

    // one session map entry
    typedef struct {
        logic [63:0] addr_key;
        logic [31:0] port_key;
        logic [31:0] map_addr;
        logic [15:0] map_port;
    } session_t;

    // reply that an outside host would send back to a session
    typedef struct {
        logic [31:0] remote;
        logic [31:0] public_addr;
        logic [15:0] remote_port;
        logic [15:0] public_port;
        logic [7:0]  proto;
    } reply_t;

    // translation predictor and queue of pending translated headers
    class translation_scoreboard;
        logic [31:0] public_addr;
        logic [15:0] port_counter;
        session_t    outbound_map[$];
        session_t    inbound_map[$];
        nst_res_t    pending[$];
        int          errors;

        function new();
            public_addr  = '0;
            port_counter = '0;
            errors       = 0;
        endfunction

        function int lookup(ref session_t map[$], input logic [63:0] ak,
                            input logic [31:0] pk);
            foreach (map[i])
                if (map[i].addr_key == ak && map[i].port_key == pk)
                    return i;
            return -1;
        endfunction

        function logic [15:0] alloc_port();
            logic [16:0] nxt;
            if (port_counter < PORT_FLOOR)
                port_counter = PORT_FLOOR;
            nxt = ({1'b0, port_counter} + 17'd1) % PORT_WRAP;
            port_counter = nxt[15:0];
            return port_counter;
        endfunction

        // ones-complement incremental update of one 16-bit word
        function logic [31:0] sum_word(logic [31:0] acc, logic [15:0] oldv,
                                       logic [15:0] newv);
            return acc + {16'h0, ~oldv} + {16'h0, newv};
        endfunction

        function logic [31:0] sum_addr(logic [31:0] acc, logic [31:0] oldv,
                                       logic [31:0] newv);
            acc = sum_word(acc, oldv[31:16], newv[31:16]);
            return sum_word(acc, oldv[15:0], newv[15:0]);
        endfunction

        function logic [15:0] fold(logic [31:0] acc);
            while (acc[31:16] != 0)
                acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
            return ~acc[15:0];
        endfunction

        // works out the translated header for an accepted request and queues it
        function nst_res_t note(header_t h);
            nst_res_t r;
            logic icmp, ok;
            logic [15:0] kdport, oldp, mport;
            logic [31:0] maddr, acc3, acc4, pk;
            logic [63:0] ak;
            session_t e;
            int s;
            r = '0;
            ok = 1'b0;
            icmp = (h.ip_protocol == PROTO_ICMP);
            if (h.frame_len < LEN_ETH) begin
                ok = 1'b0;
            end
            else if (h.ether_type == ETH_ARP) begin
                if (h.in_port == SIDE_INSIDE || h.in_port == SIDE_OUTSIDE) begin
                    r.act = (h.in_port == SIDE_INSIDE) ? ACT_OUTSIDE : ACT_INSIDE;
                    r.saddr = h.src_addr;
                    r.daddr = h.dst_addr;
                    r.sport = h.src_port;
                    r.dport = h.dst_port;
                    r.ipck = h.ip_checksum;
                    r.l4ck = h.l4_checksum;
                end
            end
            else if (h.ether_type == ETH_IPV4 && h.frame_len >= LEN_IP) begin
                if (icmp)
                    ok = h.frame_len >= LEN_UDP &&
                         (h.icmp_type == ICMP_REQUEST || h.icmp_type == ICMP_REPLY);
                else if (h.ip_protocol == PROTO_UDP)
                    ok = h.frame_len >= LEN_UDP;
                else if (h.ip_protocol == PROTO_TCP)
                    ok = h.frame_len >= LEN_TCP;
            end
            if (ok) begin
                kdport = icmp ? 16'h0 : h.dst_port;
                acc3 = 32'hFFFF + {16'h0, ~h.ip_checksum};
                acc4 = 32'hFFFF + {16'h0, ~h.l4_checksum};
                ak = {h.src_addr, h.dst_addr};
                r.saddr = h.src_addr;
                r.daddr = h.dst_addr;
                r.sport = h.src_port;
                r.dport = h.dst_port;
                if (h.in_port == SIDE_INSIDE) begin
                    pk = {h.src_port, kdport};
                    s = lookup(outbound_map, ak, pk);
                    if (s >= 0) begin
                        maddr = outbound_map[s].map_addr;
                        mport = outbound_map[s].map_port;
                    end
                    else begin
                        maddr = public_addr;
                        mport = alloc_port();
                        r.created = 1'b1;
                        if (outbound_map.size() < MAP_DEPTH) begin
                            e = '{ak, pk, maddr, mport};
                            outbound_map.push_back(e);
                        end
                        if (lookup(inbound_map, {h.dst_addr, maddr}, {kdport, mport}) < 0
                            && inbound_map.size() < MAP_DEPTH) begin
                            e = '{{h.dst_addr, maddr}, {kdport, mport},
                                  h.src_addr, h.src_port};
                            inbound_map.push_back(e);
                        end
                    end
                    acc3 = sum_addr(acc3, h.src_addr, maddr);
                    if (!icmp)
                        acc4 = sum_addr(acc4, h.src_addr, maddr);
                    acc4 = sum_word(acc4, h.src_port, mport) + 32'hFFFF;
                    r.saddr = maddr;
                    r.sport = mport;
                    r.act = ACT_OUTSIDE;
                end
                else if (h.in_port == SIDE_OUTSIDE) begin
                    oldp = icmp ? h.src_port : h.dst_port;
                    pk = icmp ? {16'h0, h.src_port} : {h.src_port, h.dst_port};
                    s = lookup(inbound_map, ak, pk);
                    if (s < 0) begin
                        ok = 1'b0;
                    end
                    else begin
                        maddr = inbound_map[s].map_addr;
                        mport = inbound_map[s].map_port;
                        acc3 = sum_addr(acc3, h.dst_addr, maddr);
                        if (!icmp)
                            acc4 = sum_addr(acc4, h.dst_addr, maddr);
                        acc4 = sum_word(acc4, oldp, mport) + 32'hFFFF;
                        r.daddr = maddr;
                        if (icmp)
                            r.sport = mport;
                        else
                            r.dport = mport;
                        r.act = ACT_INSIDE;
                    end
                end
                else begin
                    ok = 1'b0;
                end
                if (ok) begin
                    r.ipck = fold(acc3);
                    r.l4ck = fold(acc4);
                end
                else begin
                    r = '0;
                end
            end
            pending.push_back(r);
            return r;
        endfunction

        function void field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        // compares one delivered header against the oldest prediction
        function void check(nst_res_t got);
            nst_res_t want;
            if (pending.size() == 0) begin
                $error("unexpected result: action %0d", got.act);
                errors++;
                return;
            end
            want = pending.pop_front();
            field("action", want.act, got.act);
            field("src_addr_out", want.saddr, got.saddr);
            field("dst_addr_out", want.daddr, got.daddr);
            field("src_port_out", want.sport, got.sport);
            field("dst_port_out", want.dport, got.dport);
            field("ip_checksum_out", want.ipck, got.ipck);
            field("l4_checksum_out", want.l4ck, got.l4ck);
            field("session_created", want.created, got.created);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [175:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;
    logic [1:0]   m_tuser;

    translation_scoreboard sb;
    header_t flows[$];
    reply_t  replies[$];
    int      send_idle_pct;
    int      recv_stall_pct;

    napt_session_translator_unit DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        nst_res_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.act     = m_tuser;
            got.saddr   = m_tdata[31:0];
            got.daddr   = m_tdata[63:32];
            got.sport   = m_tdata[79:64];
            got.dport   = m_tdata[95:80];
            got.ipck    = m_tdata[111:96];
            got.l4ck    = m_tdata[127:112];
            got.created = m_tdata[128];
            sb.check(got);
        end
    end

    // run limit
    initial
    begin
        #80ms;
        $display("Verification failed");
        $finish;
    end

    // sends one request, records the prediction and any new session
    task automatic send_request(header_t h);
        nst_res_t r;
        reply_t rp;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= h.in_port;
        s_tdata  <= {h.l4_checksum, h.ip_checksum, h.icmp_type, h.dst_port,
                     h.src_port, h.dst_addr, h.src_addr, h.ip_protocol,
                     h.ether_type, h.frame_len};
        do
            @(posedge clk);
        while (!s_tready);
        r = sb.note(h);
        if (r.created) begin
            flows.push_back(h);
            rp.remote      = h.dst_addr;
            rp.public_addr = r.saddr;
            rp.remote_port = h.dst_port;
            rp.public_port = r.sport;
            rp.proto       = h.ip_protocol;
            replies.push_back(rp);
        end
    endtask

    // waits until every pending result has arrived
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_public_addr(logic [31:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.public_addr = v;
    endtask

    function automatic header_t flow_header(logic [1:0] side, logic [7:0] proto);
        header_t h;
        h.in_port     = side;
        h.ether_type  = ETH_IPV4;
        h.ip_protocol = proto;
        h.frame_len   = $urandom_range(1) ? LEN_TCP : 16'($urandom_range(1500, 54));
        h.src_addr    = $urandom;
        h.dst_addr    = $urandom;
        h.src_port    = 16'($urandom);
        h.dst_port    = 16'($urandom);
        h.icmp_type   = $urandom_range(1) ? ICMP_REQUEST : ICMP_REPLY;
        h.ip_checksum = 16'($urandom);
        h.l4_checksum = 16'($urandom);
        return h;
    endfunction

    function automatic logic [7:0] pick_proto();
        case ($urandom_range(2))
            0: return PROTO_ICMP;
            1: return PROTO_TCP;
            default: return PROTO_UDP;
        endcase
    endfunction

    // random request: new flows, repeated flows, replies and noise
    function automatic header_t random_header();
        header_t h;
        reply_t rp;
        int sel;
        sel = $urandom_range(99);
        if (sel < 30 || (sel < 70 && replies.size() == 0)) begin
            h = flow_header(SIDE_INSIDE, pick_proto());
        end
        else if (sel < 45) begin
            h = flows[$urandom_range(flows.size() - 1)];
            h.ip_checksum = 16'($urandom);
            h.l4_checksum = 16'($urandom);
        end
        else if (sel < 70) begin
            rp = replies[$urandom_range(replies.size() - 1)];
            h = flow_header(SIDE_OUTSIDE, rp.proto);
            h.src_addr = rp.remote;
            h.dst_addr = rp.public_addr;
            if (rp.proto == PROTO_ICMP) begin
                h.src_port  = rp.public_port;
                h.icmp_type = ICMP_REPLY;
            end
            else begin
                h.src_port = rp.remote_port;
                h.dst_port = rp.public_port;
            end
            if ($urandom_range(9) == 0)
                h.src_port ^= 16'h0001;
        end
        else begin
            h.in_port     = 2'($urandom);
            h.frame_len   = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(60));
            h.ether_type  = $urandom_range(2) == 0 ? 16'($urandom) :
                            ($urandom_range(1) ? ETH_ARP : ETH_IPV4);
            h.ip_protocol = $urandom_range(1) ? 8'($urandom) : pick_proto();
            h.src_addr    = $urandom;
            h.dst_addr    = $urandom;
            h.src_port    = 16'($urandom);
            h.dst_port    = 16'($urandom);
            h.icmp_type   = 8'($urandom);
            h.ip_checksum = 16'($urandom);
            h.l4_checksum = 16'($urandom);
        end
        return h;
    endfunction

    // directed headers: extremes, every drop reason, arp, hits and misses
    task automatic directed_phase();
        header_t h;
        header_t base;
        base = flow_header(SIDE_INSIDE, PROTO_TCP);
        base.frame_len = 16'hFFFF;
        base.src_addr  = 32'hFFFF_FFFF;
        base.src_port  = 16'hFFFF;
        send_request(base);
        h = base;
        send_request(h);
        h = flow_header(SIDE_OUTSIDE, PROTO_TCP);
        h.src_addr = base.dst_addr;
        h.dst_addr = replies[0].public_addr;
        h.src_port = base.dst_port;
        h.dst_port = replies[0].public_port;
        send_request(h);
        h.dst_port ^= 16'h8000;
        send_request(h);
        h = flow_header(SIDE_INSIDE, PROTO_UDP);
        h.l4_checksum = 16'h0;
        h.src_addr    = 32'h0;
        h.src_port    = 16'h0;
        send_request(h);
        h = flow_header(SIDE_INSIDE, PROTO_ICMP);
        h.icmp_type = ICMP_REQUEST;
        send_request(h);
        h.icmp_type = ICMP_REPLY;
        send_request(h);
        h.icmp_type = 8'd3;
        send_request(h);
        h = flow_header(SIDE_OUTSIDE, PROTO_ICMP);
        h.src_addr  = replies[replies.size() - 1].remote;
        h.dst_addr  = replies[replies.size() - 1].public_addr;
        h.src_port  = replies[replies.size() - 1].public_port;
        h.icmp_type = ICMP_REPLY;
        send_request(h);
        // frames one byte short of each bound
        h = flow_header(SIDE_INSIDE, PROTO_TCP);
        h.frame_len = LEN_TCP - 1;
        send_request(h);
        h.ip_protocol = PROTO_UDP;
        h.frame_len = LEN_UDP - 1;
        send_request(h);
        h.ip_protocol = PROTO_ICMP;
        send_request(h);
        h.frame_len = LEN_IP - 1;
        send_request(h);
        h.ether_type = ETH_ARP;
        h.frame_len = LEN_ETH - 1;
        send_request(h);
        // arp on every side
        h.frame_len = LEN_ETH;
        for (int s = 0; s < 4; s++) begin
            h.in_port = 2'(s);
            send_request(h);
        end
        // other ethertype, protocol and invalid sides
        h = flow_header(SIDE_INSIDE, 8'd47);
        send_request(h);
        h = flow_header(SIDE_INSIDE, PROTO_UDP);
        h.ether_type = 16'h86DD;
        send_request(h);
        h.ether_type = ETH_IPV4;
        h.in_port = 2'd0;
        send_request(h);
        h.in_port = 2'd3;
        send_request(h);
    endtask

    initial
    begin
        sb = new();
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part runs with the reset public address of zero
        directed_phase();
        drain();

        // four random phases, each with its own public address and idle/stall mix
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_public_addr(32'hFFFF_FFFF);
                1: write_public_addr(32'hC0A8_0001);
                2: write_public_addr(32'h0000_0000);
                default: write_public_addr($urandom);
            endcase
            send_idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 9 : 0;
            recv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 9 : 0;
            for (int n = 0; n < 163; n++)
                send_request(random_header());
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/nst_pkg.sv
rtl/nst_front.sv
rtl/nst_queue.sv
rtl/nst_back.sv
rtl/napt_session_translator_unit.sv
tb/sv/tb_top.sv
